>>> rtl/battery_charge_stage_controller_core_defines.svh
// assertion macros for the charge stage controller
// used by the top level only; the bodies need clk_i and rst_ni in scope
`ifndef BATTERY_CHARGE_STAGE_CONTROLLER_CORE_DEFINES_SVH
`define BATTERY_CHARGE_STAGE_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BCSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcsc same-cycle check failed");
`define BCSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcsc next-cycle check failed");
`else
`define BCSC_ASSERT_IMPL(lbl, ante, cons)
`define BCSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/bcsc_pkg.sv
// types, codes and reset constants of the charge stage controller
// no dependencies; imported by bcsc_step and the top level
`timescale 1ns / 1ps
`default_nettype none

package bcsc_pkg;

  // hysteresis limit of the cc/cv selection
  localparam int HOLD_LIMIT = 4;

  localparam logic signed [7:0] HOLD_CEIL  = 8'sd12;
  localparam logic signed [7:0] HOLD_FLOOR = 8'(-HOLD_LIMIT);
  localparam logic [7:0]        SWITCH_LONG  = 8'(2 * HOLD_LIMIT);
  localparam logic [7:0]        SWITCH_SHORT = 8'(HOLD_LIMIT);
  localparam logic [15:0]       DRAIN_STEP   = 16'd2;
  localparam logic [15:0]       FLOAT_ENTER  = 16'd2;

  // stage codes
  localparam logic [1:0] ST_PRE   = 2'd0;
  localparam logic [1:0] ST_CHG   = 2'd1;
  localparam logic [1:0] ST_FLT   = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  // command codes
  localparam logic [1:0] CMD_STAGE   = 2'd0;
  localparam logic [1:0] CMD_MODE    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // register indexes
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_CUTOFF_V     = 3'd0;
  localparam logic [2:0] REG_CHARGE_V     = 3'd1;
  localparam logic [2:0] REG_FLOAT_V      = 3'd2;
  localparam logic [2:0] REG_PRECHARGE_I  = 3'd3;
  localparam logic [2:0] REG_CHARGE_I     = 3'd4;
  localparam logic [2:0] REG_FLOAT_I      = 3'd5;
  localparam logic [2:0] REG_PRE_TICKS    = 3'd6;
  localparam logic [2:0] REG_FLOAT_ENTRY  = 3'd7;

  // register reset values
  localparam logic [11:0] RST_CUTOFF_V    = 12'd2000;
  localparam logic [11:0] RST_CHARGE_V    = 12'd2950;
  localparam logic [11:0] RST_FLOAT_V     = 12'd2750;
  localparam logic [11:0] RST_PRECHARGE_I = 12'd200;
  localparam logic [11:0] RST_CHARGE_I    = 12'd2000;
  localparam logic [11:0] RST_FLOAT_I     = 12'd100;
  localparam logic [14:0] RST_PRE_TICKS   = 15'd600;
  localparam logic [15:0] RST_FLOAT_ENTRY = 16'd600;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] battery_voltage;
    logic [11:0] battery_current;
  } bcsc_in_t;

  typedef struct packed {
    logic [1:0]  stage;
    logic        cc_select;
    logic [11:0] voltage_setpoint;
    logic [11:0] current_setpoint;
  } bcsc_out_t;

  typedef struct packed {
    logic [11:0] precharge_exit_v;
    logic [11:0] charge_voltage;
    logic [11:0] float_voltage;
    logic [11:0] precharge_current;
    logic [11:0] charge_current;
    logic [11:0] float_current;
    logic [14:0] precharge_ticks;
    logic [15:0] float_entry_count;
  } bcsc_cfg_t;

  typedef struct packed {
    logic [1:0]        stage;
    logic [14:0]       precharge_left;
    logic [15:0]       low_current_count;
    logic              mode_flag;
    logic signed [7:0] hold_count;
    logic [7:0]        switch_delay;
    logic [11:0]       vref;
    logic [11:0]       iref;
  } bcsc_state_t;

endpackage

`default_nettype wire

>>> rtl/bcsc_step.sv
// next-state logic of the charge stage controller for one request
// depends on bcsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcsc_step (
  input  wire bcsc_pkg::bcsc_cfg_t   cfg_i,
  input  wire bcsc_pkg::bcsc_state_t state_i,
  input  wire bcsc_pkg::bcsc_in_t    req_i,
  output bcsc_pkg::bcsc_state_t      state_o
);
  import bcsc_pkg::*;

  logic signed [7:0] hold_cur;
  logic signed [7:0] hold_dec;
  logic [15:0]       lcc_dec;
  logic [11:0]       volt;
  logic [11:0]       curr;
  bcsc_state_t       nxt;

  assign hold_cur = state_i.hold_count;
  assign hold_dec = hold_cur - 8'sd1;
  assign lcc_dec  = state_i.low_current_count - DRAIN_STEP;
  assign volt     = req_i.battery_voltage;
  assign curr     = req_i.battery_current;

  always_comb begin
    nxt = state_i;
    case (req_i.cmd)
      CMD_STAGE: begin
        case (state_i.stage)
          ST_PRE: begin
            if (volt < cfg_i.precharge_exit_v) begin
              if (state_i.precharge_left != '0) begin
                nxt.precharge_left = state_i.precharge_left - 15'd1;
              end else begin
                nxt.stage = ST_FAULT;
              end
            end else begin
              nxt.stage = ST_CHG;
              nxt.iref  = cfg_i.charge_current;
            end
          end
          ST_CHG: begin
            // low-current countdown only runs in voltage mode
            if (!state_i.mode_flag) begin
              if (curr < cfg_i.float_current) begin
                nxt.low_current_count = lcc_dec;
                if (lcc_dec < FLOAT_ENTER) begin
                  nxt.stage = ST_FLT;
                end
              end else if (state_i.low_current_count < cfg_i.float_entry_count) begin
                nxt.low_current_count = state_i.low_current_count + 16'd1;
              end
            end
          end
          ST_FLT: begin
            nxt.vref = cfg_i.float_voltage;
            nxt.iref = cfg_i.float_current;
          end
          default: begin
            nxt.mode_flag = 1'b0;
          end
        endcase
      end
      CMD_MODE: begin
        if (volt > state_i.vref) begin
          if (hold_cur < HOLD_CEIL) begin
            nxt.hold_count = hold_cur + 8'sd1;
          end
          if (state_i.switch_delay != '0) begin
            nxt.switch_delay = state_i.switch_delay - 8'd1;
          end else begin
            nxt.mode_flag = 1'b0;
          end
        end else if (volt < state_i.vref) begin
          if (hold_dec < HOLD_FLOOR) begin
            nxt.hold_count   = HOLD_FLOOR;
            nxt.mode_flag    = 1'b1;
            nxt.switch_delay = SWITCH_LONG;
          end else begin
            nxt.hold_count = hold_dec;
          end
        end
        // overcurrent in float drops back to charge
        if (curr > state_i.iref && !nxt.mode_flag && state_i.stage == ST_FLT) begin
          nxt.stage        = ST_CHG;
          nxt.vref         = cfg_i.charge_voltage;
          nxt.iref         = cfg_i.charge_current;
          nxt.mode_flag    = 1'b1;
          nxt.switch_delay = SWITCH_SHORT;
        end
      end
      CMD_RESTART: begin
        nxt.stage             = ST_PRE;
        nxt.precharge_left    = cfg_i.precharge_ticks;
        nxt.iref              = cfg_i.precharge_current;
        nxt.vref              = cfg_i.charge_voltage;
        nxt.low_current_count = cfg_i.float_entry_count;
      end
      default: begin
      end
    endcase
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

>>> rtl/battery_charge_stage_controller_core.sv
// Charge stage controller for one lead-acid channel: each request (command plus one
// voltage and current sample) yields one result with stage, cc/cv mode and the voltage
// and current setpoints after the update. A request is captured in an input register,
// runs through one pass of compare-and-count logic into the state and the result
// register, from which its result is presented; one request per cycle is sustained
// while results are taken, the result register letting the next request in while a
// result waits. Setpoint and threshold registers sit on an APB port at byte address
// 4*index; the user must write them only while no request is in flight, which the
// block itself does not enforce. Depends on bcsc_pkg, bcsc_step and the defines.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_charge_stage_controller_core_defines.svh"

module battery_charge_stage_controller_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire bcsc_pkg::bcsc_in_t          in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output bcsc_pkg::bcsc_out_t              out_data_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [bcsc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire [31:0]                       pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import bcsc_pkg::*;

  bcsc_cfg_t   cfg_q;
  bcsc_state_t state_q, state_d;
  bcsc_in_t    in_q;
  bcsc_out_t   out_q;
  logic        in_valid_q, in_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        cfg_write;
  logic [2:0]  cfg_idx;
  logic signed [7:0] hold_q;
  logic        restart_step;
  logic        fault_step;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.precharge_exit_v  <= RST_CUTOFF_V;
      cfg_q.charge_voltage    <= RST_CHARGE_V;
      cfg_q.float_voltage     <= RST_FLOAT_V;
      cfg_q.precharge_current <= RST_PRECHARGE_I;
      cfg_q.charge_current    <= RST_CHARGE_I;
      cfg_q.float_current     <= RST_FLOAT_I;
      cfg_q.precharge_ticks   <= RST_PRE_TICKS;
      cfg_q.float_entry_count <= RST_FLOAT_ENTRY;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_CUTOFF_V:    cfg_q.precharge_exit_v  <= pwdata[11:0];
        REG_CHARGE_V:    cfg_q.charge_voltage    <= pwdata[11:0];
        REG_FLOAT_V:     cfg_q.float_voltage     <= pwdata[11:0];
        REG_PRECHARGE_I: cfg_q.precharge_current <= pwdata[11:0];
        REG_CHARGE_I:    cfg_q.charge_current    <= pwdata[11:0];
        REG_FLOAT_I:     cfg_q.float_current     <= pwdata[11:0];
        REG_PRE_TICKS:   cfg_q.precharge_ticks   <= pwdata[14:0];
        default:         cfg_q.float_entry_count <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CUTOFF_V:    prdata = 32'(cfg_q.precharge_exit_v);
      REG_CHARGE_V:    prdata = 32'(cfg_q.charge_voltage);
      REG_FLOAT_V:     prdata = 32'(cfg_q.float_voltage);
      REG_PRECHARGE_I: prdata = 32'(cfg_q.precharge_current);
      REG_CHARGE_I:    prdata = 32'(cfg_q.charge_current);
      REG_FLOAT_I:     prdata = 32'(cfg_q.float_current);
      REG_PRE_TICKS:   prdata = 32'(cfg_q.precharge_ticks);
      default:         prdata = 32'(cfg_q.float_entry_count);
    endcase
  end

  // ---------------- request pipeline ----------------
  // the held request moves on when the result register is empty or being drained
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_valid_d  = (in_valid_i && in_ready_o) || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  bcsc_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .req_i   (in_q),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.stage             <= ST_PRE;
      state_q.precharge_left    <= RST_PRE_TICKS;
      state_q.low_current_count <= RST_FLOAT_ENTRY;
      state_q.mode_flag         <= 1'b1;
      state_q.hold_count        <= '0;
      state_q.switch_delay      <= '0;
      state_q.vref              <= RST_CHARGE_V;
      state_q.iref              <= RST_PRECHARGE_I;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q.stage            <= state_d.stage;
      out_q.cc_select        <= state_d.mode_flag;
      out_q.voltage_setpoint <= state_d.vref;
      out_q.current_setpoint <= state_d.iref;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign hold_q       = state_q.hold_count;
  assign restart_step = advance && in_q.cmd == CMD_RESTART;
  assign fault_step   = advance && in_q.cmd == CMD_STAGE && state_q.stage == ST_FAULT;

  // ---------------- checks ----------------
  `BCSC_ASSERT_NEXT(a_step_fills_result, advance, out_valid_q)
  `BCSC_ASSERT_NEXT(a_restart_precharge, restart_step, state_q.stage == ST_PRE)
  `BCSC_ASSERT_NEXT(a_fault_clears_mode, fault_step, !state_q.mode_flag && state_q.stage == ST_FAULT)
  `BCSC_ASSERT_IMPL(a_hold_in_range, out_valid_q, hold_q <= HOLD_CEIL && hold_q >= HOLD_FLOOR)

endmodule

`default_nettype wire

>>> test/testbench.sv
// self-checking bench for battery_charge_stage_controller_core: directed and random
// requests, register settings over apb, a scoreboard class with its own stage model
// depends on bcsc_pkg and the core rtl only
`timescale 1ns / 1ps

module testbench;
  import bcsc_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         NUM_REGS    = 8;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 235;
  localparam int         CYCLE_LIMIT = 400000;

  class charge_scoreboard;
    logic [15:0]       regs [NUM_REGS];
    logic [1:0]        stage;
    logic [14:0]       pre_left;
    logic [15:0]       low_cnt;
    logic              cc_mode;
    logic signed [7:0] hold;
    logic [7:0]        sw_delay;
    logic [11:0]       vref;
    logic [11:0]       iref;
    bcsc_out_t         expected_q [$];
    int mismatches, checked, requests, float_entries, float_exits, timeouts;

    function new();
      regs[REG_CUTOFF_V]    = 16'(RST_CUTOFF_V);
      regs[REG_CHARGE_V]    = 16'(RST_CHARGE_V);
      regs[REG_FLOAT_V]     = 16'(RST_FLOAT_V);
      regs[REG_PRECHARGE_I] = 16'(RST_PRECHARGE_I);
      regs[REG_CHARGE_I]    = 16'(RST_CHARGE_I);
      regs[REG_FLOAT_I]     = 16'(RST_FLOAT_I);
      regs[REG_PRE_TICKS]   = 16'(RST_PRE_TICKS);
      regs[REG_FLOAT_ENTRY] = RST_FLOAT_ENTRY;
      reload();
      cc_mode = 1'b1;
      hold = '0;
      sw_delay = '0;
      mismatches = 0;
      checked = 0;
      requests = 0;
      float_entries = 0;
      float_exits = 0;
      timeouts = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      if (idx == REG_PRE_TICKS) regs[idx] = {1'b0, val[14:0]};
      else if (idx == REG_FLOAT_ENTRY) regs[idx] = val[15:0];
      else regs[idx] = {4'd0, val[11:0]};
    endfunction

    // restart keeps mode, hold and switch delay
    function void reload();
      stage    = ST_PRE;
      pre_left = regs[REG_PRE_TICKS][14:0];
      iref     = regs[REG_PRECHARGE_I][11:0];
      vref     = regs[REG_CHARGE_V][11:0];
      low_cnt  = regs[REG_FLOAT_ENTRY];
    endfunction

    function void fail_note(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void stage_step(logic [11:0] v, logic [11:0] i);
      case (stage)
        ST_PRE: begin
          if (v < regs[REG_CUTOFF_V][11:0]) begin
            if (pre_left != 0) begin
              pre_left = pre_left - 15'd1;
            end else begin
              stage = ST_FAULT;
              timeouts++;
            end
          end else begin
            stage = ST_CHG;
            iref  = regs[REG_CHARGE_I][11:0];
          end
        end
        ST_CHG: begin
          if (!cc_mode) begin
            if (i < regs[REG_FLOAT_I][11:0]) begin
              low_cnt = low_cnt - DRAIN_STEP;
              if (low_cnt < FLOAT_ENTER) begin
                stage = ST_FLT;
                float_entries++;
              end
            end else if (low_cnt < regs[REG_FLOAT_ENTRY]) begin
              low_cnt = low_cnt + 16'd1;
            end
          end
        end
        ST_FLT: begin
          vref = regs[REG_FLOAT_V][11:0];
          iref = regs[REG_FLOAT_I][11:0];
        end
        default: cc_mode = 1'b0;
      endcase
    endfunction

    function void mode_step(logic [11:0] v, logic [11:0] i);
      if (v > vref) begin
        if (hold < HOLD_CEIL) hold = hold + 8'sd1;
        if (sw_delay != 0) sw_delay = sw_delay - 8'd1;
        else cc_mode = 1'b0;
      end else if (v < vref) begin
        hold = hold - 8'sd1;
        if (hold < HOLD_FLOOR) begin
          cc_mode  = 1'b1;
          sw_delay = SWITCH_LONG;
          hold     = HOLD_FLOOR;
        end
      end
      // overcurrent in float drops back to charge
      if (i > iref && !cc_mode && stage == ST_FLT) begin
        stage    = ST_CHG;
        vref     = regs[REG_CHARGE_V][11:0];
        iref     = regs[REG_CHARGE_I][11:0];
        cc_mode  = 1'b1;
        sw_delay = SWITCH_SHORT;
        float_exits++;
      end
    endfunction

    function void note_request(bcsc_in_t r);
      bcsc_out_t exp_r;
      requests++;
      case (r.cmd)
        CMD_STAGE:   stage_step(r.battery_voltage, r.battery_current);
        CMD_MODE:    mode_step(r.battery_voltage, r.battery_current);
        CMD_RESTART: reload();
        default: ;
      endcase
      exp_r.stage            = stage;
      exp_r.cc_select        = cc_mode;
      exp_r.voltage_setpoint = vref;
      exp_r.current_setpoint = iref;
      expected_q.push_back(exp_r);
    endfunction

    function void check_result(bcsc_out_t got);
      bcsc_out_t exp_r;
      if (expected_q.size() == 0) begin
        fail_note($sformatf("result with nothing expected: stage %0d mode %0d v %0d i %0d",
                            got.stage, got.cc_select, got.voltage_setpoint,
                            got.current_setpoint));
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.stage !== exp_r.stage || got.cc_select !== exp_r.cc_select ||
          got.voltage_setpoint !== exp_r.voltage_setpoint ||
          got.current_setpoint !== exp_r.current_setpoint) begin
        fail_note($sformatf(
          "result %0d: exp stage %0d mode %0d v %0d i %0d, got stage %0d mode %0d v %0d i %0d",
          checked, exp_r.stage, exp_r.cc_select, exp_r.voltage_setpoint,
          exp_r.current_setpoint, got.stage, got.cc_select, got.voltage_setpoint,
          got.current_setpoint));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  bcsc_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bcsc_out_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  logic [15:0] plan [NUM_REGS];
  charge_scoreboard sb;

  battery_charge_stage_controller_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.expected_q.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // note the request before the result so the queue is always current
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic logic [11:0] sat12(input int x);
    if (x < 0) return 12'h000;
    if (x > 4095) return 12'hfff;
    return x[11:0];
  endfunction

  function automatic bcsc_in_t pack_req(logic [1:0] cmd, logic [11:0] v, logic [11:0] i);
    bcsc_in_t r;
    r.cmd = cmd;
    r.battery_voltage = v;
    r.battery_current = i;
    return r;
  endfunction

  // aim samples at the thresholds the present state compares against
  function automatic bcsc_in_t make_request();
    bcsc_in_t r;
    int pick, vsel, isel, fc;
    pick = $urandom_range(0, 99);
    vsel = $urandom_range(0, 99);
    isel = $urandom_range(0, 99);
    fc   = int'(sb.regs[REG_FLOAT_I]);
    if (sb.stage == ST_FAULT && pick < 15) r.cmd = CMD_RESTART;
    else if (pick < 46) r.cmd = CMD_STAGE;
    else if (pick < 92) r.cmd = CMD_MODE;
    else if (pick < 94) r.cmd = CMD_RESTART;
    else if (pick < 97) r.cmd = CMD_UNUSED;
    else r.cmd = CMD_STAGE;

    if (vsel < 10) r.battery_voltage = $urandom_range(0, 1) ? 12'hfff : 12'h000;
    else if (vsel < 25) r.battery_voltage = 12'($urandom_range(0, 4095));
    else if (r.cmd == CMD_MODE) begin
      if (vsel < 70) r.battery_voltage = sat12(int'(sb.vref) + int'($urandom_range(1, 16)));
      else if (vsel < 90)
        r.battery_voltage = sat12(int'(sb.vref) - int'($urandom_range(1, 16)));
      else r.battery_voltage = sb.vref;
    end else begin
      r.battery_voltage = sat12(int'(sb.regs[REG_CUTOFF_V]) + int'($urandom_range(0, 12)) - 6);
    end

    if (isel < 10) r.battery_current = $urandom_range(0, 1) ? 12'hfff : 12'h000;
    else if (isel < 25) r.battery_current = 12'($urandom_range(0, 4095));
    else if (r.cmd == CMD_MODE)
      r.battery_current = sat12(int'(sb.iref) + int'($urandom_range(0, 40)) - 8);
    else if (isel < 75) r.battery_current = sat12(fc - int'($urandom_range(1, 8)));
    else r.battery_current = sat12(fc + int'($urandom_range(0, 8)));
    return r;
  endfunction

  task automatic send_request(input bcsc_in_t r);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic cfg_read(input int idx, output logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_plan();
    logic [31:0] rd;
    for (int k = REG_CUTOFF_V; k <= REG_FLOAT_ENTRY; k++) cfg_write(k, {16'd0, plan[k]});
    for (int k = REG_CUTOFF_V; k <= REG_FLOAT_ENTRY; k++) begin
      cfg_read(k, rd);
      if (rd !== {16'd0, sb.regs[k]})
        sb.fail_note($sformatf("register %0d readback: exp %0d got %0d", k, sb.regs[k], rd));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unused command, equal voltage, precharge countdown
    send_request(pack_req(CMD_UNUSED, 12'hfff, 12'hfff));
    send_request(pack_req(CMD_MODE, RST_CHARGE_V, 12'h000));
    send_request(pack_req(CMD_STAGE, 12'h000, 12'h000));
    // drive hold below its floor, forcing current mode and the long switch delay
    repeat (5) send_request(pack_req(CMD_MODE, 12'h000, 12'h000));
    send_request(pack_req(CMD_RESTART, 12'haaa, 12'h555));
    send_request(pack_req(CMD_STAGE, 12'hfff, 12'hfff));
    // count the switch delay out until voltage mode takes over
    repeat (9) send_request(pack_req(CMD_MODE, 12'hfff, 12'hfff));

    // precharge timeout into fault, then a quick trip through float and back
    drain();
    cfg_write(REG_PRE_TICKS, 32'd0);
    cfg_write(REG_FLOAT_ENTRY, 32'd2);
    send_request(pack_req(CMD_RESTART, 12'h000, 12'h000));
    send_request(pack_req(CMD_STAGE, 12'h000, 12'h000));
    send_request(pack_req(CMD_STAGE, 12'h000, 12'h000));
    send_request(pack_req(CMD_RESTART, 12'h000, 12'h000));
    send_request(pack_req(CMD_STAGE, 12'hfff, 12'h000));
    send_request(pack_req(CMD_STAGE, 12'h123, 12'h000));
    send_request(pack_req(CMD_STAGE, 12'h123, 12'h000));
    send_request(pack_req(CMD_MODE, RST_FLOAT_V, 12'hfff));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      for (int k = REG_CUTOFF_V; k <= REG_FLOAT_ENTRY; k++) begin
        if (p == 1) plan[k] = (k == REG_PRE_TICKS) ? 16'h7fff :
                              (k == REG_FLOAT_ENTRY) ? 16'hffff : 16'h0fff;
        else if (p == 2) plan[k] = 16'd0;
        else plan[k] = 16'($urandom_range(0, 4095));
      end
      if (p == 0) begin
        plan[REG_CUTOFF_V]    = 16'(RST_CUTOFF_V);
        plan[REG_CHARGE_V]    = 16'(RST_CHARGE_V);
        plan[REG_FLOAT_V]     = 16'(RST_FLOAT_V);
        plan[REG_PRECHARGE_I] = 16'(RST_PRECHARGE_I);
        plan[REG_CHARGE_I]    = 16'(RST_CHARGE_I);
        plan[REG_FLOAT_I]     = 16'(RST_FLOAT_I);
        plan[REG_PRE_TICKS]   = 16'(RST_PRE_TICKS);
        plan[REG_FLOAT_ENTRY] = RST_FLOAT_ENTRY;
      end else if (p > 2) begin
        // short counters so float entry and timeout are reachable
        plan[REG_FLOAT_I]     = 16'($urandom_range(1, 4095));
        plan[REG_PRE_TICKS]   = (p == 3) ? 16'd0 : 16'($urandom_range(0, 20));
        plan[REG_FLOAT_ENTRY] = (p < 6) ? 16'(p - 3) : 16'($urandom_range(4, 40));
      end
      apply_plan();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      send_request(pack_req(CMD_RESTART, 12'($urandom_range(0, 4095)),
                            12'($urandom_range(0, 4095))));
      repeat (PHASE_ITEMS - 1) send_request(make_request());
    end

    drain();
    $display("%0d requests over %0d register settings, %0d results compared, %0d mismatches",
             sb.requests, PHASES + 1, sb.checked, sb.mismatches);
    $display("float entries %0d, overcurrent returns %0d, precharge timeouts %0d",
             sb.float_entries, sb.float_exits, sb.timeouts);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> battery_charge_stage_controller_core.f
+incdir+rtl
rtl/bcsc_pkg.sv
rtl/bcsc_step.sv
rtl/battery_charge_stage_controller_core.sv
test/testbench.sv
